/* src/csic_pkg.sv */
// Shared types, constants and helper function of the character stream calculator.
`timescale 1ns / 1ps

package csic_pkg;

    localparam int VALUE_BITS = 32;
    localparam int LINE_CHARS = 127;
    localparam int FIELD_BITS = 32;
    localparam int CNT_BITS   = $clog2(LINE_CHARS + 1);
    localparam int ITER_BITS  = $clog2(VALUE_BITS);

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] ESC_RESET  = 8'd27;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_USAGE   = 2'd1,
        ST_DIVZERO = 2'd2,
        ST_QUIT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NONE = 3'd4,
        OP_BAD  = 3'd5
    } op_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } in_word_t;

    typedef struct packed {
        status_t                       status;
        logic signed [FIELD_BITS-1:0]  first_operand;
        logic [1:0]                    operator_code;
        logic signed [FIELD_BITS-1:0]  second_operand;
        logic signed [FIELD_BITS-1:0]  result_value;
    } out_word_t;

    typedef struct packed {
        logic take_char;
        logic eval;
        logic prep;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic calc;
        logic loop;
        logic iter_last;
    } dp_status_t;

    // Sign-extend a value and keep the low bits of an output field.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+FIELD_BITS-1:0] ext;
        ext = {{FIELD_BITS{v[VALUE_BITS-1]}}, v};
        return ext[FIELD_BITS-1:0];
    endfunction

endpackage

/* src/csic_ctrl.sv */
// Controller state machine that sequences parsing, evaluation and result hand-off.
`timescale 1ns / 1ps

module csic_ctrl
    import csic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic       char_line_end,
    output logic       char_ready,
    output logic       res_valid,
    input  logic       res_ready,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_STEP = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   char_acc;

    assign char_acc = char_valid && char_ready;

    always_comb
    begin
        state_next = state_reg;
        char_ready = 1'b0;
        res_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                char_ready = 1'b1;
                if (char_acc)
                begin
                    if (char_line_end)
                    begin
                        cmd.eval   = 1'b1;
                        state_next = dp_stat.calc ? S_PREP : S_OUT;
                    end
                    else
                    begin
                        cmd.take_char = 1'b1;
                    end
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = dp_stat.loop ? S_STEP : S_FIN;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (dp_stat.iter_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Characters of the next line may flow in while the result waits.
                res_valid  = 1'b1;
                char_ready = !char_line_end;
                if (char_acc)
                begin
                    cmd.take_char = 1'b1;
                end
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_eval_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (char_acc && char_line_end) |-> !res_valid)
        else $error("end-of-line word accepted while a result is pending");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(cmd.eval) || $past(cmd.finish)))
        else $error("result shown without an evaluation or finish step");

    a_finish_after_loop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> ($past(cmd.prep) || $past(cmd.step && dp_stat.iter_last)))
        else $error("finish step without a completed calculation");

endmodule

/* src/csic_datapath.sv */
// Datapath: line parser registers, shared shift-add multiply and restoring divide unit.
`timescale 1ns / 1ps

module csic_datapath
    import csic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_word_t   char_word,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t dp_stat,
    output out_word_t  res_word
);

    typedef enum logic [5:0] {
        PH_LEFT_SPACE   = 6'b000001,
        PH_LEFT_DIGITS  = 6'b000010,
        PH_OP_SPACE     = 6'b000100,
        PH_RIGHT_SPACE  = 6'b001000,
        PH_RIGHT_DIGITS = 6'b010000,
        PH_DONE         = 6'b100000
    } phase_t;

    localparam logic [ITER_BITS-1:0] ITER_START = ITER_BITS'(VALUE_BITS - 1);
    localparam logic [CNT_BITS-1:0]  CNT_LIMIT  = CNT_BITS'(LINE_CHARS);

    logic [7:0]            esc_reg;
    phase_t                phase_reg, phase_next;
    logic [VALUE_BITS-1:0] left_acc_reg, left_acc_next;
    logic                  left_neg_reg, left_neg_next;
    logic [VALUE_BITS-1:0] right_acc_reg, right_acc_next;
    logic                  right_neg_reg, right_neg_next;
    op_t                   op_reg, op_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  first_esc_reg, first_esc_next;

    logic [VALUE_BITS-1:0] work_a_reg;
    logic [VALUE_BITS-1:0] work_b_reg;
    logic [VALUE_BITS:0]   work_acc_reg;
    logic [1:0]            calc_op_reg;
    logic                  neg_q_reg;
    logic [ITER_BITS-1:0]  iter_reg;
    out_word_t             res_word_reg;

    logic [7:0]            c;
    logic                  is_space, is_minus, is_digit, op_hit, to_op, take;
    op_t                   op_dec;
    logic [VALUE_BITS-1:0] digit_val, left_add, right_add;
    logic [VALUE_BITS-1:0] a_val, b_val;
    logic                  quit, usage, divzero;
    logic [VALUE_BITS:0]   rem_shift;
    logic [VALUE_BITS+1:0] diff;
    logic [VALUE_BITS-1:0] fin_val;

    assign c         = char_word.char_code;
    assign is_space  = (c == CH_SPACE);
    assign is_minus  = (c == CH_MINUS);
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign digit_val = {{(VALUE_BITS-4){1'b0}}, c[3:0]};
    assign left_add  = (left_acc_reg << 3) + (left_acc_reg << 1) + digit_val;
    assign right_add = (right_acc_reg << 3) + (right_acc_reg << 1) + digit_val;
    assign take      = cmd.take_char && (count_reg < CNT_LIMIT);

    always_comb
    begin
        op_hit = 1'b1;
        op_dec = OP_BAD;
        case (c)
            CH_PLUS:  op_dec = OP_ADD;
            CH_MINUS: op_dec = OP_SUB;
            CH_STAR:  op_dec = OP_MUL;
            CH_SLASH: op_dec = OP_DIV;
            default:  op_hit = 1'b0;
        endcase
    end

    // Parser next-state logic; an evaluation clears the whole line.
    always_comb
    begin
        phase_next     = phase_reg;
        left_acc_next  = left_acc_reg;
        left_neg_next  = left_neg_reg;
        right_acc_next = right_acc_reg;
        right_neg_next = right_neg_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        first_esc_next = first_esc_reg;
        to_op          = 1'b0;
        if (cmd.eval)
        begin
            phase_next     = PH_LEFT_SPACE;
            left_acc_next  = '0;
            left_neg_next  = 1'b0;
            right_acc_next = '0;
            right_neg_next = 1'b0;
            op_next        = OP_NONE;
            count_next     = '0;
            first_esc_next = 1'b0;
        end
        else if (take)
        begin
            if ((count_reg == '0) && (c == esc_reg))
            begin
                first_esc_next = 1'b1;
            end
            count_next = count_reg + 1'b1;
            case (phase_reg)
                PH_LEFT_SPACE:
                begin
                    if (is_minus)
                    begin
                        left_neg_next = 1'b1;
                        phase_next    = PH_LEFT_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        left_acc_next = left_add;
                        phase_next    = PH_LEFT_DIGITS;
                    end
                    else if (!is_space)
                    begin
                        to_op = 1'b1;
                    end
                end
                PH_LEFT_DIGITS:
                begin
                    if (is_digit)
                    begin
                        left_acc_next = left_add;
                    end
                    else
                    begin
                        to_op = 1'b1;
                    end
                end
                PH_OP_SPACE:
                begin
                    to_op = 1'b1;
                end
                PH_RIGHT_SPACE:
                begin
                    if (is_minus)
                    begin
                        right_neg_next = 1'b1;
                        phase_next     = PH_RIGHT_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        right_acc_next = right_add;
                        phase_next     = PH_RIGHT_DIGITS;
                    end
                    else if (!is_space)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_RIGHT_DIGITS:
                begin
                    if (is_digit)
                    begin
                        right_acc_next = right_add;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
            if (to_op)
            begin
                if (is_space)
                begin
                    phase_next = PH_OP_SPACE;
                end
                else if (op_hit)
                begin
                    op_next    = op_dec;
                    phase_next = PH_RIGHT_SPACE;
                end
                else
                begin
                    op_next    = OP_BAD;
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg       <= ESC_RESET;
            phase_reg     <= PH_LEFT_SPACE;
            left_acc_reg  <= '0;
            left_neg_reg  <= 1'b0;
            right_acc_reg <= '0;
            right_neg_reg <= 1'b0;
            op_reg        <= OP_NONE;
            count_reg     <= '0;
            first_esc_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                esc_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            left_acc_reg  <= left_acc_next;
            left_neg_reg  <= left_neg_next;
            right_acc_reg <= right_acc_next;
            right_neg_reg <= right_neg_next;
            op_reg        <= op_next;
            count_reg     <= count_next;
            first_esc_reg <= first_esc_next;
        end
    end

    // Line evaluation decode.
    assign a_val   = left_neg_reg ? (VALUE_BITS'(0) - left_acc_reg) : left_acc_reg;
    assign b_val   = right_neg_reg ? (VALUE_BITS'(0) - right_acc_reg) : right_acc_reg;
    assign quit    = first_esc_reg;
    assign usage   = (op_reg == OP_NONE) || (op_reg == OP_BAD);
    assign divzero = (op_reg == OP_DIV) && (right_acc_reg == '0);

    // The line registers are already cleared after the evaluation, so the loop
    // decision looks at the latched operator.
    assign dp_stat.calc      = !quit && !usage && !divzero;
    assign dp_stat.loop      = (calc_op_reg == OP_MUL[1:0]) || (calc_op_reg == OP_DIV[1:0]);
    assign dp_stat.iter_last = (iter_reg == '0);

    // One restoring division step: shift in the next dividend bit and try the subtract.
    assign rem_shift = {work_acc_reg[VALUE_BITS-1:0], work_a_reg[VALUE_BITS-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, work_b_reg};

    always_comb
    begin
        case (calc_op_reg)
            OP_ADD[1:0]: fin_val = work_a_reg + work_b_reg;
            OP_SUB[1:0]: fin_val = work_a_reg - work_b_reg;
            OP_MUL[1:0]: fin_val = work_acc_reg[VALUE_BITS-1:0];
            default:     fin_val = neg_q_reg ? (VALUE_BITS'(0) - work_a_reg) : work_a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            work_a_reg   <= a_val;
            work_b_reg   <= b_val;
            work_acc_reg <= '0;
            calc_op_reg  <= op_reg[1:0];
            iter_reg     <= ITER_START;
            res_word_reg.result_value <= '0;
            if (quit)
            begin
                res_word_reg.status         <= ST_QUIT;
                res_word_reg.first_operand  <= '0;
                res_word_reg.operator_code  <= '0;
                res_word_reg.second_operand <= '0;
            end
            else if (usage)
            begin
                res_word_reg.status         <= ST_USAGE;
                res_word_reg.first_operand  <= to_field(a_val);
                res_word_reg.operator_code  <= '0;
                res_word_reg.second_operand <= '0;
            end
            else
            begin
                res_word_reg.status         <= divzero ? ST_DIVZERO : ST_OK;
                res_word_reg.first_operand  <= to_field(a_val);
                res_word_reg.operator_code  <= op_reg[1:0];
                res_word_reg.second_operand <= to_field(b_val);
            end
        end
        if (cmd.prep && (calc_op_reg == OP_DIV[1:0]))
        begin
            work_a_reg <= work_a_reg[VALUE_BITS-1] ? (VALUE_BITS'(0) - work_a_reg) : work_a_reg;
            work_b_reg <= work_b_reg[VALUE_BITS-1] ? (VALUE_BITS'(0) - work_b_reg) : work_b_reg;
            neg_q_reg  <= work_a_reg[VALUE_BITS-1] ^ work_b_reg[VALUE_BITS-1];
        end
        if (cmd.step)
        begin
            iter_reg <= iter_reg - 1'b1;
            if (calc_op_reg == OP_MUL[1:0])
            begin
                if (work_b_reg[0])
                begin
                    work_acc_reg <= {1'b0, work_acc_reg[VALUE_BITS-1:0] + work_a_reg};
                end
                work_a_reg <= work_a_reg << 1;
                work_b_reg <= work_b_reg >> 1;
            end
            else
            begin
                if (!diff[VALUE_BITS+1])
                begin
                    work_acc_reg <= diff[VALUE_BITS:0];
                    work_a_reg   <= {work_a_reg[VALUE_BITS-2:0], 1'b1};
                end
                else
                begin
                    work_acc_reg <= rem_shift;
                    work_a_reg   <= {work_a_reg[VALUE_BITS-2:0], 1'b0};
                end
            end
        end
        if (cmd.finish)
        begin
            res_word_reg.result_value <= to_field(fin_val);
        end
    end

    assign res_word = res_word_reg;

endmodule

/* src/char_stream_integer_calculator_top.sv */
// Top level of the character stream four-function integer calculator.
`timescale 1ns / 1ps

// Usage: the char channel carries one word per character of a text line
// (char_word.char_code) or an end-of-line marker (char_word.line_end = 1).
// Character words are taken at one per cycle and produce no result. The
// end-of-line word evaluates the line and produces exactly one result word
// on the res channel: status, both operands, operator code and result.
// From the edge that accepts the end-of-line word, quit, usage error and
// division by zero go straight to res_valid; add and subtract pass through
// a prepare and a finish step; multiply and divide also run the shared
// shift-add / restoring-divide unit, which retires one bit per cycle.
// While the unit is busy, char_ready is low. While a result waits, the next
// line's characters are still taken, but its end-of-line word is held off
// until the result has been taken, so a stalled receiver loses nothing.
// The cfg channel writes the escape code; it is always ready and must only
// be written while no line evaluation is in progress. Reset clears the line
// state and sets the escape code to 27; no clearing pass is needed.

module char_stream_integer_calculator_top
    import csic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  in_word_t   char_word,
    output logic       res_valid,
    input  logic       res_ready,
    output out_word_t  res_word,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;
    logic       cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    csic_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (char_valid),
        .char_line_end (char_word.line_end),
        .char_ready    (char_ready),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .dp_stat       (dp_stat),
        .cmd           (cmd)
    );

    csic_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_word (char_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .dp_stat   (dp_stat),
        .res_word  (res_word)
    );

endmodule
